### rtl/sn2_pkg.sv
// Package for the 2-D simplex noise block: fixed-point formats, skew constants,
// and the small gradient and hash helper functions.
// Used by simplex_noise_2d; depends on nothing.
package sn2_pkg;

    localparam int FRAC_BITS = 16;
    localparam int NOISE_W   = FRAC_BITS + 3;
    localparam int COORD_W   = 32;
    localparam int CELL_FB   = 30;
    localparam int OFS_FB    = 24;
    localparam int SKEW_W    = 64;
    localparam int CI_W      = SKEW_W - (FRAC_BITS + CELL_FB);
    localparam int X0F_W     = 66 - FRAC_BITS + CELL_FB - 30;
    localparam int OFS_W     = 28;
    localparam int DOT_W     = OFS_W + 1;
    localparam int SQ_W      = 2 * OFS_W + 1;
    localparam int T_W       = 24;
    localparam int TT_W      = 2 * T_W;
    localparam int CON_W     = T_W + 1 + DOT_W;
    localparam int SUM_W     = CON_W + 2;
    localparam int RND_SH    = 48 - FRAC_BITS;

    localparam logic signed [30:0] F2_Q30 = 31'sd393016785;
    localparam logic signed [29:0] G2_Q30 = 30'sd226908346;
    localparam logic signed [OFS_W-1:0] G2_Q24  = OFS_W'(3545443);
    localparam logic signed [OFS_W-1:0] ONE_Q24 = OFS_W'(1) <<< OFS_FB;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    // Reduce an 8-bit hash to one of the twelve gradient codes.
    function automatic logic [3:0] mod12(input logic [7:0] v);
        logic [7:0] r;
        r = v;
        if (r >= 8'd192) r = r - 8'd192;
        if (r >= 8'd96)  r = r - 8'd96;
        if (r >= 8'd48)  r = r - 8'd48;
        if (r >= 8'd24)  r = r - 8'd24;
        if (r >= 8'd12)  r = r - 8'd12;
        return r[3:0];
    endfunction

    // Dot product of the edge gradient chosen by a gradient code with a corner offset.
    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [3:0] g,
        input logic signed [OFS_W-1:0] dx,
        input logic signed [OFS_W-1:0] dy
    );
        logic signed [DOT_W-1:0] ex;
        logic signed [DOT_W-1:0] ey;
        logic signed [DOT_W-1:0] d;
        ex = DOT_W'(dx);
        ey = DOT_W'(dy);
        unique case (g)
            4'd0:    d = ex + ey;
            4'd1:    d = ey - ex;
            4'd2:    d = ex - ey;
            4'd3:    d = -ex - ey;
            4'd4:    d = ex;
            4'd5:    d = -ex;
            4'd6:    d = ex;
            4'd7:    d = -ex;
            4'd8:    d = ey;
            4'd9:    d = -ey;
            4'd10:   d = ey;
            4'd11:   d = -ey;
            default: d = '0;
        endcase
        return d;
    endfunction

endpackage

### rtl/simplex_noise_2d.sv
// Top level of the 2-D simplex noise block: twelve-stage pipeline with six
// copies of the permutation table.
// Depends on sn2_pkg.

// The block accepts one transaction per clock unless stalled and returns the
// noise value of an evaluate transaction; a load transaction writes one
// permutation entry and returns nothing. The twelve stages are set by the chain
// of multiplies (skew, unskew, distance squares, two squarings of the falloff,
// gradient weighting) and by the two dependent permutation lookups. Each lookup
// level has its own three table copies, so the first-level reads of one point
// happen in the same cycle as the second-level reads of the point ahead. Loads
// are written into the table at the stage where the first lookup is made, which
// keeps loads and evaluates in the order they were accepted. A stall on a valid
// output freezes the whole pipeline, and in_stall is raised in that same cycle.
module simplex_noise_2d
    import sn2_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic                       func,
    input  logic [7:0]                 table_index,
    input  logic [7:0]                 table_value,
    input  logic signed [COORD_W-1:0]  x_coord,
    input  logic signed [COORD_W-1:0]  y_coord,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic signed [NOISE_W-1:0]  noise_value
);

    localparam int NSTG = 11;

    // Pipeline control: the whole pipe moves when the output can take data.
    logic            en;
    logic [NSTG:1]   vld_reg;
    logic [NSTG:1]   evl_reg;
    logic            out_valid_reg;

    assign en       = !out_valid_reg || !out_stall;
    assign in_stall = !en;
    assign out_valid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            evl_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[NSTG-1:1], in_valid};
            evl_reg       <= {evl_reg[NSTG-1:1], func == FUNC_EVAL};
            out_valid_reg <= vld_reg[NSTG] && evl_reg[NSTG];
        end
    end

    // Stage 1: skew product (x + y) * F2.
    logic signed [COORD_W:0]   sum_xy;
    logic signed [SKEW_W-1:0]  skw1_next;
    logic signed [COORD_W-1:0] x1_reg, y1_reg;
    logic signed [SKEW_W-1:0]  skw1_reg;
    logic [7:0]                idx1_reg, val1_reg;

    assign sum_xy    = (COORD_W+1)'(x_coord) + (COORD_W+1)'(y_coord);
    assign skw1_next = SKEW_W'(sum_xy) * SKEW_W'(F2_Q30);

    // Stage 2: cell indices by flooring the skewed point.
    logic signed [SKEW_W-1:0]  vx, vy;
    logic signed [COORD_W-1:0] x2_reg, y2_reg;
    logic signed [CI_W-1:0]    ci2_reg, cj2_reg;
    logic [7:0]                idx2_reg, val2_reg;

    assign vx = (SKEW_W'(x1_reg) <<< CELL_FB) + skw1_reg;
    assign vy = (SKEW_W'(y1_reg) <<< CELL_FB) + skw1_reg;

    // Stage 3: unskew product (i + j) * G2.
    logic signed [CI_W:0]      cij;
    logic signed [X0F_W-1:0]   t3_next;
    logic signed [COORD_W-1:0] x3_reg, y3_reg;
    logic signed [CI_W-1:0]    ci3_reg, cj3_reg;
    logic signed [X0F_W-1:0]   t3_reg;
    logic [7:0]                idx3_reg, val3_reg;

    assign cij     = (CI_W+1)'(ci2_reg) + (CI_W+1)'(cj2_reg);
    assign t3_next = X0F_W'(cij) * X0F_W'(G2_Q30);

    // Stage 4: offset of the point from the first corner.
    logic signed [X0F_W-1:0]   x0f, y0f;
    logic signed [OFS_W-1:0]   x0_4_reg, y0_4_reg;
    logic [7:0]                ii4_reg, jj4_reg;
    logic [7:0]                idx4_reg, val4_reg;

    assign x0f = (X0F_W'(x3_reg) <<< (CELL_FB - FRAC_BITS))
                 - (X0F_W'(ci3_reg) <<< CELL_FB) + t3_reg;
    assign y0f = (X0F_W'(y3_reg) <<< (CELL_FB - FRAC_BITS))
                 - (X0F_W'(cj3_reg) <<< CELL_FB) + t3_reg;

    // Stage 5: middle corner choice, corner offsets, first table lookup.
    // Ties step in y.
    logic                      step_x;
    logic                      tbl_wr;
    logic signed [OFS_W-1:0]   dx5_next [3];
    logic signed [OFS_W-1:0]   dy5_next [3];
    logic signed [OFS_W-1:0]   dx5_reg [3];
    logic signed [OFS_W-1:0]   dy5_reg [3];
    logic                      i1_5_reg;
    logic [7:0]                ii5_reg;

    assign step_x = x0_4_reg > y0_4_reg;
    assign tbl_wr = en && vld_reg[4] && (evl_reg[4] == FUNC_LOAD);

    assign dx5_next[0] = x0_4_reg;
    assign dy5_next[0] = y0_4_reg;
    assign dx5_next[1] = x0_4_reg - (step_x ? ONE_Q24 : '0) + G2_Q24;
    assign dy5_next[1] = y0_4_reg - (step_x ? '0 : ONE_Q24) + G2_Q24;
    assign dx5_next[2] = x0_4_reg - ONE_Q24 + (G2_Q24 <<< 1);
    assign dy5_next[2] = y0_4_reg - ONE_Q24 + (G2_Q24 <<< 1);

    // Table copies: banks 0 to 2 serve the lookup on j, banks 3 to 5 the
    // lookup on i plus the first hash.
    logic [7:0] bank_addr [6];
    logic [7:0] bank_rd_reg [6];

    assign bank_addr[0] = jj4_reg;
    assign bank_addr[1] = jj4_reg + {7'd0, !step_x};
    assign bank_addr[2] = jj4_reg + 8'd1;
    assign bank_addr[3] = ii5_reg + bank_rd_reg[0];
    assign bank_addr[4] = ii5_reg + {7'd0, i1_5_reg} + bank_rd_reg[1];
    assign bank_addr[5] = ii5_reg + 8'd1 + bank_rd_reg[2];

    for (genvar k = 0; k < 6; k++)
    begin : g_bank
        logic [7:0] perm_mem [0:255];

        always_ff @(posedge clk)
        begin
            if (tbl_wr)
            begin
                perm_mem[idx4_reg] <= val4_reg;
            end
            if (en)
            begin
                bank_rd_reg[k] <= perm_mem[bank_addr[k]];
            end
        end
    end

    // Stages 6 to 10: per-corner falloff and gradient weighting.
    logic signed [OFS_W-1:0]   dx6_reg [3];
    logic signed [OFS_W-1:0]   dy6_reg [3];
    logic [SQ_W-1:0]           sqx6_reg [3];
    logic [SQ_W-1:0]           sqy6_reg [3];
    logic signed [SQ_W:0]      q7 [3];
    logic [T_W-1:0]            t7_reg [3];
    logic                      neg7_reg [3];
    logic signed [DOT_W-1:0]   dot7_reg [3];
    logic [TT_W-1:0]           tt8_reg [3];
    logic                      neg8_reg [3];
    logic signed [DOT_W-1:0]   dot8_reg [3];
    logic [TT_W-1:0]           tt9_reg [3];
    logic                      neg9_reg [3];
    logic signed [DOT_W-1:0]   dot9_reg [3];
    logic signed [CON_W-1:0]   con10_reg [3];
    logic [T_W-1:0]            t2_9 [3];
    logic [T_W-1:0]            t4_10 [3];

    for (genvar c = 0; c < 3; c++)
    begin : g_corner
        assign q7[c]    = ((SQ_W+1)'(1) <<< 47)
                          - (SQ_W+1)'(sqx6_reg[c]) - (SQ_W+1)'(sqy6_reg[c]);
        assign t2_9[c]  = tt8_reg[c][TT_W-1:T_W];
        assign t4_10[c] = tt9_reg[c][TT_W-1:T_W];
    end

    // Stage 11 and output: sum, scale by 70, round, saturate.
    logic signed [SUM_W-1:0]   sum11_reg;
    logic signed [63:0]        scaled;
    logic signed [63:0]        rnd;
    logic signed [63:0]        lim;
    logic signed [NOISE_W-1:0] noise_next;
    logic signed [NOISE_W-1:0] noise_reg;

    assign scaled = 64'(sum11_reg) * 64'sd70 + (64'sd1 <<< (RND_SH - 1));
    assign rnd    = scaled >>> RND_SH;
    assign lim    = 64'sd2 <<< FRAC_BITS;

    always_comb
    begin
        priority if (rnd > lim)
        begin
            noise_next = NOISE_W'(lim);
        end
        else if (rnd < -lim)
        begin
            noise_next = NOISE_W'(-lim);
        end
        else
        begin
            noise_next = NOISE_W'(rnd);
        end
    end

    assign noise_value = noise_reg;

    // Datapath registers; they carry no reset.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x1_reg   <= x_coord;
            y1_reg   <= y_coord;
            skw1_reg <= skw1_next;
            idx1_reg <= table_index;
            val1_reg <= table_value;

            x2_reg   <= x1_reg;
            y2_reg   <= y1_reg;
            ci2_reg  <= vx[SKEW_W-1:FRAC_BITS+CELL_FB];
            cj2_reg  <= vy[SKEW_W-1:FRAC_BITS+CELL_FB];
            idx2_reg <= idx1_reg;
            val2_reg <= val1_reg;

            x3_reg   <= x2_reg;
            y3_reg   <= y2_reg;
            ci3_reg  <= ci2_reg;
            cj3_reg  <= cj2_reg;
            t3_reg   <= t3_next;
            idx3_reg <= idx2_reg;
            val3_reg <= val2_reg;

            x0_4_reg <= OFS_W'(x0f >>> (CELL_FB - OFS_FB));
            y0_4_reg <= OFS_W'(y0f >>> (CELL_FB - OFS_FB));
            ii4_reg  <= ci3_reg[7:0];
            jj4_reg  <= cj3_reg[7:0];
            idx4_reg <= idx3_reg;
            val4_reg <= val3_reg;

            i1_5_reg <= step_x;
            ii5_reg  <= ii4_reg;

            for (int c = 0; c < 3; c++)
            begin
                dx5_reg[c]  <= dx5_next[c];
                dy5_reg[c]  <= dy5_next[c];

                dx6_reg[c]  <= dx5_reg[c];
                dy6_reg[c]  <= dy5_reg[c];
                sqx6_reg[c] <= SQ_W'(dx5_reg[c]) * SQ_W'(dx5_reg[c]);
                sqy6_reg[c] <= SQ_W'(dy5_reg[c]) * SQ_W'(dy5_reg[c]);

                t7_reg[c]   <= q7[c][47:24];
                neg7_reg[c] <= q7[c][SQ_W];
                dot7_reg[c] <= grad_dot(mod12(bank_rd_reg[3 + c]), dx6_reg[c], dy6_reg[c]);

                tt8_reg[c]  <= TT_W'(t7_reg[c]) * TT_W'(t7_reg[c]);
                neg8_reg[c] <= neg7_reg[c];
                dot8_reg[c] <= dot7_reg[c];

                tt9_reg[c]  <= TT_W'(t2_9[c]) * TT_W'(t2_9[c]);
                neg9_reg[c] <= neg8_reg[c];
                dot9_reg[c] <= dot8_reg[c];

                con10_reg[c] <= neg9_reg[c] ? '0
                                : CON_W'(signed'({1'b0, t4_10[c]})) * CON_W'(dot9_reg[c]);
            end

            sum11_reg <= SUM_W'(con10_reg[0]) + SUM_W'(con10_reg[1])
                         + SUM_W'(con10_reg[2]);
            noise_reg <= noise_next;
        end
    end

endmodule
